>>> hw/rtl/message_queue_priority_waiters_defines.svh
// ----------------------------------------------------------------------------
// Message queue with priority waiters: assertion macros
// Shared helpers for the concurrent checks on the queue ports.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_QUEUE_PRIORITY_WAITERS_DEFINES_SVH
`define MESSAGE_QUEUE_PRIORITY_WAITERS_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define MQPW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MQPW_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/mqpw_pkg.sv
// ----------------------------------------------------------------------------
// Message queue with priority waiters: package
// Request/result types, codes and default sizes.
// ----------------------------------------------------------------------------
package mqpw_pkg;

  localparam int unsigned MSG_DEPTH_DEF  = 16;
  localparam int unsigned WAIT_DEPTH_DEF = 8;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_RECV = 2'd1,
    OP_TRY  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_GOT    = 3'd0,
    ST_QUEUED = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_STORED = 3'd3,
    ST_HANDED = 3'd4,
    ST_FULL   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MPOP,
    S_WPOP,
    S_WALK
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  requester_id;
    logic [4:0]  requester_priority;
    logic [31:0] message_word;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] message_out;
    logic [7:0]  woken_thread;
    logic [4:0]  woken_priority;
  } rsp_t;

  typedef struct packed {
    logic [7:0] id;
    logic [4:0] prio;
  } waiter_t;

endpackage

>>> hw/rtl/message_queue_priority_waiters.sv
// ----------------------------------------------------------------------------
// Message queue with priority waiters
// Kernel message queue: FIFO message ring plus a priority-sorted list of
// blocked receivers, both held in synchronous RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   A request (send, blocking receive, try receive) is taken on a rising edge
//   with start_i high and busy_o low. Each request produces one result on
//   result_o, marked by result_valid_o for exactly one cycle; the receiver
//   cannot stall it. Operation code 3 is ignored and gives no result.
// Throughput:
//   - send that stores, full drops, empty try, receive queued into an empty
//     list: result the cycle after the request, busy_o stays low, so a new
//     request can be taken every cycle.
//   - receive of a stored message, send handed to a waiter: one RAM read;
//     busy_o is high in S_MPOP/S_WPOP, whose result is registered from the read word.
//   - blocking receive into a non-empty waiter list: sorted insert walks the
//     list from its tail, one entry shifted per cycle, busy_o high while in
//     S_WALK; each waiter with a larger priority number moves up a slot
//     (at most WAIT_DEPTH-1). The single waiter-RAM port pair sets this rate.
// Reset: counts and pointers clear at once; RAM contents are left as is and
//   only the entries counted from each head pointer are ever used.
// ----------------------------------------------------------------------------
module message_queue_priority_waiters #(
  parameter int unsigned MSG_DEPTH  = mqpw_pkg::MSG_DEPTH_DEF,
  parameter int unsigned WAIT_DEPTH = mqpw_pkg::WAIT_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  mqpw_pkg::req_t req_i,
  output logic           result_valid_o,
  output mqpw_pkg::rsp_t result_o
);

  // Address and count widths (at least one bit for single-entry stores)
  localparam int unsigned MAW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
  localparam int unsigned WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned MCW = $clog2(MSG_DEPTH + 1);
  localparam int unsigned WCW = $clog2(WAIT_DEPTH + 1);

  // Ring pointer helpers
  function automatic logic [MAW-1:0] m_next(input logic [MAW-1:0] p);
    return (p == MAW'(MSG_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [WAW-1:0] w_next(input logic [WAW-1:0] p);
    return (p == WAW'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [WAW-1:0] w_prev(input logic [WAW-1:0] p);
    return (p == '0) ? WAW'(WAIT_DEPTH - 1) : p - 1'b1;
  endfunction

  // Control state
  mqpw_pkg::state_e state_q, state_d;
  logic [MAW-1:0]   mhead_q, mhead_d, mtail_q, mtail_d;
  logic [MCW-1:0]   mcount_q, mcount_d;
  logic [WAW-1:0]   whead_q, whead_d, wtail_q, wtail_d;
  logic [WCW-1:0]   wcount_q, wcount_d;
  logic             res_valid_q, res_valid_d;

  // Payload registers
  mqpw_pkg::req_t   req_q, req_d;
  mqpw_pkg::rsp_t   res_q, res_d;
  logic [WAW-1:0]   cur_q, cur_d;    // write slot of the insert walk
  logic [WCW-1:0]   rem_q, rem_d;    // waiters still ahead of the slot

  // Message RAM ports
  logic [31:0]      msg_mem [MSG_DEPTH];
  logic             m_we, m_re;
  logic [MAW-1:0]   m_waddr, m_raddr;
  logic [31:0]      m_wdata, m_rdata_q;

  // Waiter RAM ports
  mqpw_pkg::waiter_t wait_mem [WAIT_DEPTH];
  logic              w_we, w_re;
  logic [WAW-1:0]    w_waddr, w_raddr;
  mqpw_pkg::waiter_t w_wdata, w_rdata_q;
  mqpw_pkg::waiter_t new_waiter;

  assign new_waiter.id   = req_q.requester_id;
  assign new_waiter.prio = req_q.requester_priority;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    mhead_d     = mhead_q;
    mtail_d     = mtail_q;
    mcount_d    = mcount_q;
    whead_d     = whead_q;
    wtail_d     = wtail_q;
    wcount_d    = wcount_q;
    req_d       = req_q;
    cur_d       = cur_q;
    rem_d       = rem_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    m_we        = 1'b0;
    m_waddr     = mtail_q;
    m_wdata     = req_i.message_word;
    m_re        = 1'b0;
    m_raddr     = mhead_q;
    w_we        = 1'b0;
    w_waddr     = wtail_q;
    w_wdata     = new_waiter;
    w_re        = 1'b0;
    w_raddr     = whead_q;

    unique case (state_q)
      mqpw_pkg::S_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          unique case (req_i.operation)
            mqpw_pkg::OP_SEND: begin
              if (wcount_q != '0) begin
                // hand to the front waiter: fetch it first
                w_re    = 1'b1;
                w_raddr = whead_q;
                state_d = mqpw_pkg::S_WPOP;
              end else if (mcount_q == MCW'(MSG_DEPTH)) begin
                res_valid_d  = 1'b1;
                res_d.status = mqpw_pkg::ST_FULL;
              end else begin
                m_we         = 1'b1;
                m_waddr      = mtail_q;
                mtail_d      = m_next(mtail_q);
                mcount_d     = mcount_q + 1'b1;
                res_valid_d  = 1'b1;
                res_d.status = mqpw_pkg::ST_STORED;
              end
            end
            mqpw_pkg::OP_RECV, mqpw_pkg::OP_TRY: begin
              if (mcount_q != '0) begin
                m_re    = 1'b1;
                m_raddr = mhead_q;
                state_d = mqpw_pkg::S_MPOP;
              end else if (req_i.operation == mqpw_pkg::OP_TRY) begin
                res_valid_d  = 1'b1;
                res_d.status = mqpw_pkg::ST_EMPTY;
              end else if (wcount_q == WCW'(WAIT_DEPTH)) begin
                res_valid_d  = 1'b1;
                res_d.status = mqpw_pkg::ST_FULL;
              end else if (wcount_q == '0) begin
                // empty list: write straight into the tail slot
                w_we         = 1'b1;
                w_waddr      = wtail_q;
                w_wdata.id   = req_i.requester_id;
                w_wdata.prio = req_i.requester_priority;
                wtail_d      = w_next(wtail_q);
                wcount_d     = wcount_q + 1'b1;
                res_valid_d  = 1'b1;
                res_d.status = mqpw_pkg::ST_QUEUED;
              end else begin
                // sorted insert: start at the tail, look at the last waiter
                w_re    = 1'b1;
                w_raddr = w_prev(wtail_q);
                cur_d   = wtail_q;
                rem_d   = wcount_q;
                state_d = mqpw_pkg::S_WALK;
              end
            end
            default: ;
          endcase
        end
      end

      mqpw_pkg::S_MPOP: begin
        res_valid_d       = 1'b1;
        res_d.status      = mqpw_pkg::ST_GOT;
        res_d.message_out = m_rdata_q;
        mhead_d           = m_next(mhead_q);
        mcount_d          = mcount_q - 1'b1;
        state_d           = mqpw_pkg::S_IDLE;
      end

      mqpw_pkg::S_WPOP: begin
        res_valid_d          = 1'b1;
        res_d.status         = mqpw_pkg::ST_HANDED;
        res_d.message_out    = req_q.message_word;
        res_d.woken_thread   = w_rdata_q.id;
        res_d.woken_priority = w_rdata_q.prio;
        whead_d              = w_next(whead_q);
        wcount_d             = wcount_q - 1'b1;
        state_d              = mqpw_pkg::S_IDLE;
      end

      mqpw_pkg::S_WALK: begin
        // w_rdata_q holds the waiter just ahead of cur_q while rem_q != 0
        if ((rem_q != '0) && (req_q.requester_priority < w_rdata_q.prio)) begin
          w_we    = 1'b1;
          w_waddr = cur_q;
          w_wdata = w_rdata_q;
          cur_d   = w_prev(cur_q);
          rem_d   = rem_q - 1'b1;
          // prefetch the next one down; unused if rem_d reaches zero
          w_re    = 1'b1;
          w_raddr = w_prev(w_prev(cur_q));
        end else begin
          w_we         = 1'b1;
          w_waddr      = cur_q;
          w_wdata      = new_waiter;
          wtail_d      = w_next(wtail_q);
          wcount_d     = wcount_q + 1'b1;
          res_valid_d  = 1'b1;
          res_d.status = mqpw_pkg::ST_QUEUED;
          state_d      = mqpw_pkg::S_IDLE;
        end
      end

      default: state_d = mqpw_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mqpw_pkg::S_IDLE;
      mhead_q     <= '0;
      mtail_q     <= '0;
      mcount_q    <= '0;
      whead_q     <= '0;
      wtail_q     <= '0;
      wcount_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mhead_q     <= mhead_d;
      mtail_q     <= mtail_d;
      mcount_q    <= mcount_d;
      whead_q     <= whead_d;
      wtail_q     <= wtail_d;
      wcount_q    <= wcount_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    cur_q <= cur_d;
    rem_q <= rem_d;
  end

  // ---------------------------------------------------------------------------
  // RAMs: one write and one registered read port each
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (m_we) begin
      msg_mem[m_waddr] <= m_wdata;
    end
    if (m_re) begin
      m_rdata_q <= msg_mem[m_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wait_mem[w_waddr] <= w_wdata;
    end
    if (w_re) begin
      w_rdata_q <= wait_mem[w_raddr];
    end
  end

  assign busy_o         = (state_q != mqpw_pkg::S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

>>> hw/rtl/mqpw_checker.sv
// ----------------------------------------------------------------------------
// Message queue with priority waiters: port checker
// Concurrent checks on the request/result ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "message_queue_priority_waiters_defines.svh"

module mqpw_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input mqpw_pkg::req_t req_i,
  input logic           result_valid_o,
  input mqpw_pkg::rsp_t result_o
);

  logic take, take_op, take_nop, known_op, no_payload;

  assign take       = start_i && !busy_o;
  assign known_op   = (req_i.operation == mqpw_pkg::OP_SEND) ||
                      (req_i.operation == mqpw_pkg::OP_RECV) ||
                      (req_i.operation == mqpw_pkg::OP_TRY);
  assign take_nop   = take && !known_op;
  assign take_op    = take && known_op;
  assign no_payload = (result_o.status == mqpw_pkg::ST_EMPTY) ||
                      (result_o.status == mqpw_pkg::ST_STORED) ||
                      (result_o.status == mqpw_pkg::ST_QUEUED) ||
                      (result_o.status == mqpw_pkg::ST_FULL);

  // a valid request either answers next cycle or keeps the block busy
  `MQPW_ASSERT(a_req_progress, take_op |=> (result_valid_o || busy_o), "request lost")
  // an ignored code leaves no trace
  `MQPW_ASSERT(a_nop_silent, take_nop |=> (!result_valid_o && !busy_o), "unused op acted")
  // a multi-cycle request ends with its result
  `MQPW_ASSERT(a_busy_ends_result, $fell(busy_o) |-> result_valid_o, "busy ended without result")
  // statuses without a message carry zero payload
  `MQPW_ASSERT(a_zero_payload, (result_valid_o && no_payload) |->
      ((result_o.message_out == '0) && (result_o.woken_thread == '0) &&
       (result_o.woken_priority == '0)), "stray payload")

endmodule

bind message_queue_priority_waiters mqpw_checker u_mqpw_checker (.*);
